// ===== rtl/wavetable_pitch_range_select_macros.svh =====
// Assertion macros shared by the checker of the wavetable band selector.
// No dependencies; included by bare file name.
`ifndef WAVETABLE_PITCH_RANGE_SELECT_MACROS_SVH
`define WAVETABLE_PITCH_RANGE_SELECT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WTPRS_ASSERT_IMPLY(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define WTPRS_ASSERT_NEXT(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("next-cycle check failed");

`endif

// ===== rtl/wtprs_pkg.sv =====
// Shared constants and types of the wavetable pitch range selector.
// No dependencies; used by the log2 pipeline and the top level.
`timescale 1ns / 1ps

package wtprs_pkg;

	localparam int LOG_FRAC_BITS  = 16;
	localparam int FREQ_FRAC_BITS = 8;

	localparam int FREQ_W   = 32;
	localparam int MSB_W    = 5;
	localparam int MANT_W   = 32;
	localparam int LOWEST_W = 24;
	localparam int RNG_W    = 6;
	localparam int BANDS_W  = 4;
	localparam int FACTOR_W = 16;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	// Signed integer part of log2 needs seven bits for any fraction width of the input.
	localparam int INT_W   = 7;
	localparam int LG_W    = INT_W + LOG_FRAC_BITS;
	localparam int DIFF_W  = ((LG_W > LOWEST_W) ? LG_W : LOWEST_W) + 1;
	localparam int PITCH_W = DIFF_W + BANDS_W + 2;

	localparam logic signed [LOWEST_W-1:0] LOWEST_RST = 24'sd224690;
	localparam logic [RNG_W-1:0]           RANGES_RST = 6'd36;
	localparam logic [BANDS_W-1:0]         BANDS_RST  = 4'd3;

	typedef enum logic [1:0] {
		REG_LOWEST = 2'd0,
		REG_RANGES = 2'd1,
		REG_BANDS  = 2'd2
	} reg_idx_t;

	// Result of the log2 pipeline: integer part as a bit position, fraction bits.
	typedef struct packed {
		logic                     zero;
		logic [MSB_W-1:0]         msb;
		logic [LOG_FRAC_BITS-1:0] frac;
	} lg_t;

endpackage

// ===== rtl/wtprs_log2.sv =====
// Pipelined log2 of the frequency magnitude: magnitude, normalize, then one
// mantissa squaring per stage. Depends on wtprs_pkg.
`timescale 1ns / 1ps

module wtprs_log2 (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [wtprs_pkg::FREQ_W-1:0]     frequency,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output wtprs_pkg::lg_t                          result
);

	localparam int NST = wtprs_pkg::LOG_FRAC_BITS + 2;
	localparam int LFB = wtprs_pkg::LOG_FRAC_BITS;
	localparam int MW  = wtprs_pkg::MANT_W;

	function automatic logic [wtprs_pkg::MSB_W-1:0] msb_pos(input logic [MW-1:0] v);
		logic [wtprs_pkg::MSB_W-1:0] pos;
		pos = '0;
		for (int i = 0; i < MW; i++) begin
			if (v[i]) begin
				pos = wtprs_pkg::MSB_W'(i);
			end
		end
		return pos;
	endfunction

	logic valid_s [NST];
	logic adv [NST+1];

	// A stage takes a new beat when it is empty or its content moves on.
	assign adv[NST] = out_ready;
	for (genvar k = 0; k < NST; k++) begin : g_adv
		assign adv[k] = !valid_s[k] || adv[k+1];
	end

	assign in_ready  = adv[0];
	assign out_valid = valid_s[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
			valid_s[1] <= 1'b0;
		end else begin
			if (adv[0]) begin
				valid_s[0] <= in_valid;
			end
			if (adv[1]) begin
				valid_s[1] <= valid_s[0];
			end
		end
	end

	logic [MW-1:0]                mag_s1;
	logic [MW-1:0]                mant_s2;
	logic [wtprs_pkg::MSB_W-1:0]  msb_s2;
	logic                         zero_s2;
	logic [wtprs_pkg::MSB_W-1:0]  lead_pos;

	assign lead_pos = msb_pos(mag_s1);

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			// The most negative input yields exactly 2^31, which still fits unsigned.
			mag_s1 <= frequency[wtprs_pkg::FREQ_W-1] ? (~frequency + 1'b1) : frequency;
		end
		if (adv[1]) begin
			msb_s2  <= lead_pos;
			zero_s2 <= (mag_s1 == '0);
			mant_s2 <= mag_s1 << (~lead_pos);
		end
	end

	logic [MW-1:0]               mant_s [LFB];
	logic [LFB-1:0]              frac_s [LFB];
	logic [wtprs_pkg::MSB_W-1:0] msb_s  [LFB];
	logic                        zero_s [LFB];

	for (genvar j = 0; j < LFB; j++) begin : g_sq
		logic [MW-1:0]               m_in;
		logic [LFB-1:0]              f_in;
		logic [wtprs_pkg::MSB_W-1:0] b_in;
		logic                        z_in;
		logic [2*MW-1:0]             sq;

		if (j == 0) begin : g_first
			assign m_in = mant_s2;
			assign f_in = '0;
			assign b_in = msb_s2;
			assign z_in = zero_s2;
		end else begin : g_next
			assign m_in = mant_s[j-1];
			assign f_in = frac_s[j-1];
			assign b_in = msb_s[j-1];
			assign z_in = zero_s[j-1];
		end

		assign sq = m_in * m_in;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j+2] <= 1'b0;
			end else if (adv[j+2]) begin
				valid_s[j+2] <= valid_s[j+1];
			end
		end

		// A square of two or more emits a one and renormalizes by one extra bit.
		always_ff @(posedge clk) begin
			if (adv[j+2]) begin
				mant_s[j] <= sq[2*MW-1] ? sq[2*MW-1:MW] : sq[2*MW-2:MW-1];
				frac_s[j] <= {f_in[LFB-2:0], sq[2*MW-1]};
				msb_s[j]  <= b_in;
				zero_s[j] <= z_in;
			end
		end
	end

	assign result.zero = zero_s[LFB-1];
	assign result.msb  = msb_s[LFB-1];
	assign result.frac = frac_s[LFB-1];

endmodule

// ===== rtl/wavetable_pitch_range_select.sv =====
// Throughput: one frequency per cycle unless a stalled output backs up the pipeline;
// one 32x32 squaring per log2 stage sets the depth.
// Every stage carries its own valid bit, so a stalled output only holds the full stages
// and empty stages behind it keep taking beats.
// Reset (arst_n low, asynchronous) empties the pipeline and loads the register defaults.
// Top level: APB register file, log2 pipeline, pitch scaling, clamp and index stages.
`timescale 1ns / 1ps

module wavetable_pitch_range_select (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [wtprs_pkg::ADDR_W-1:0]          paddr,
	input  logic [wtprs_pkg::DATA_W-1:0]          pwdata,
	output logic [wtprs_pkg::DATA_W-1:0]          prdata,
	output logic                                  pready,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [wtprs_pkg::FREQ_W-1:0]   frequency,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [wtprs_pkg::RNG_W-1:0]           upper_range_index,
	output logic [wtprs_pkg::RNG_W-1:0]           lower_range_index,
	output logic [wtprs_pkg::FACTOR_W-1:0]        interp_factor
);

	localparam int LFB     = wtprs_pkg::LOG_FRAC_BITS;
	localparam int DIFF_W  = wtprs_pkg::DIFF_W;
	localparam int PITCH_W = wtprs_pkg::PITCH_W;
	localparam int RW      = wtprs_pkg::RNG_W;
	localparam int FW      = wtprs_pkg::FACTOR_W;

	localparam logic signed [DIFF_W-1:0]  NEG_ONE   = DIFF_W'(-(longint'(1) <<< LFB));
	localparam logic signed [PITCH_W-1:0] PITCH_ONE = PITCH_W'(longint'(1) <<< LFB);

	// Register file.
	logic signed [wtprs_pkg::LOWEST_W-1:0] lowest_q;
	logic [RW-1:0]                         ranges_q;
	logic [wtprs_pkg::BANDS_W-1:0]         bands_q;
	wtprs_pkg::reg_idx_t                   reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = wtprs_pkg::reg_idx_t'(paddr[wtprs_pkg::ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lowest_q <= wtprs_pkg::LOWEST_RST;
			ranges_q <= wtprs_pkg::RANGES_RST;
			bands_q  <= wtprs_pkg::BANDS_RST;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				wtprs_pkg::REG_LOWEST: lowest_q <= pwdata[wtprs_pkg::LOWEST_W-1:0];
				wtprs_pkg::REG_RANGES: ranges_q <= pwdata[RW-1:0];
				wtprs_pkg::REG_BANDS:  bands_q  <= pwdata[wtprs_pkg::BANDS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			wtprs_pkg::REG_LOWEST: prdata = wtprs_pkg::DATA_W'(unsigned'(lowest_q));
			wtprs_pkg::REG_RANGES: prdata = wtprs_pkg::DATA_W'(ranges_q);
			wtprs_pkg::REG_BANDS:  prdata = wtprs_pkg::DATA_W'(bands_q);
			default:               prdata = '0;
		endcase
	end

	// Log2 pipeline.
	logic           lg_valid;
	logic           lg_ready;
	wtprs_pkg::lg_t lg;

	wtprs_log2 u_log2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.frequency (frequency),
		.out_valid (lg_valid),
		.out_ready (lg_ready),
		.result    (lg)
	);

	// Three back-end stages: offset from the lowest table, scale, clamp.
	logic valid_s1, valid_s2, valid_s3;
	logic adv_s1, adv_s2, adv_s3;

	assign adv_s3   = !valid_s3 || out_ready;
	assign adv_s2   = !valid_s2 || adv_s3;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign lg_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= lg_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	logic signed [wtprs_pkg::INT_W-1:0] int_part;
	logic signed [wtprs_pkg::LG_W-1:0]  lg_val;
	logic signed [DIFF_W-1:0]           diff_s1;
	logic signed [PITCH_W-1:0]          pitch_s2;

	assign int_part = $signed({2'b00, lg.msb}) - wtprs_pkg::INT_W'(wtprs_pkg::FREQ_FRAC_BITS);
	assign lg_val   = $signed({int_part, lg.frac});

	// Zero frequency sits one octave below the lowest table, so its offset is minus one.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			diff_s1 <= lg.zero ? NEG_ONE : (DIFF_W'(lg_val) - DIFF_W'(lowest_q));
		end
		if (adv_s2) begin
			pitch_s2 <= PITCH_ONE + PITCH_W'($signed({1'b0, bands_q})) * PITCH_W'(diff_s1);
		end
	end

	logic [RW-1:0]             last_idx;
	logic signed [PITCH_W-1:0] top;
	logic signed [PITCH_W-1:0] clamped;
	logic [RW-1:0]             upper_idx;
	logic [LFB+FW-1:0]         frac_wide;

	assign last_idx  = (ranges_q == '0) ? '0 : ranges_q - 1'b1;
	assign top       = PITCH_W'({last_idx, {LFB{1'b0}}});
	assign upper_idx = clamped[LFB+RW-1:LFB];
	assign frac_wide = {clamped[LFB-1:0], {FW{1'b0}}};

	always_comb begin
		if (pitch_s2 < 0) begin
			clamped = '0;
		end else if (pitch_s2 > top) begin
			clamped = top;
		end else begin
			clamped = pitch_s2;
		end
	end

	logic [RW-1:0] upper_s3;
	logic [RW-1:0] lower_s3;
	logic [FW-1:0] factor_s3;

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			upper_s3  <= upper_idx;
			lower_s3  <= (upper_idx < last_idx) ? upper_idx + 1'b1 : upper_idx;
			factor_s3 <= frac_wide[LFB+FW-1:LFB];
		end
	end

	assign out_valid         = valid_s3;
	assign upper_range_index = upper_s3;
	assign lower_range_index = lower_s3;
	assign interp_factor     = factor_s3;

endmodule

// ===== rtl/wtprs_checker.sv =====
// Port-level checks of the wavetable pitch range selector, bound to the top level.
// Depends on wtprs_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "wavetable_pitch_range_select_macros.svh"

module wtprs_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [wtprs_pkg::RNG_W-1:0]        upper_range_index,
	input logic [wtprs_pkg::RNG_W-1:0]        lower_range_index,
	input logic [wtprs_pkg::FACTOR_W-1:0]     interp_factor
);

	// A result beat that is not taken stays on the port unchanged.
	`WTPRS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`WTPRS_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(upper_range_index) && $stable(lower_range_index) && $stable(interp_factor))

	// The second table is the next one up, or the same one at the top.
	`WTPRS_ASSERT_IMPLY(a_idx_pair, clk, arst_n, out_valid, (lower_range_index == upper_range_index) || (lower_range_index == upper_range_index + 6'd1))

	// Equal indices only happen at a clamp, where the fraction is zero.
	`WTPRS_ASSERT_IMPLY(a_top_frac, clk, arst_n, out_valid && (lower_range_index == upper_range_index), interp_factor == '0)

endmodule

bind wavetable_pitch_range_select wtprs_checker u_wtprs_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (out_valid),
	.out_ready         (out_ready),
	.upper_range_index (upper_range_index),
	.lower_range_index (lower_range_index),
	.interp_factor     (interp_factor)
);

// ===== bench/wavetable_pitch_range_select_test.sv =====
// Testbench of the wavetable pitch range selector: a directed table, then random beats.
// Depends on wtprs_pkg and wavetable_pitch_range_select; checks use typed values or a predictor.
`timescale 1ns / 1ps

module wavetable_pitch_range_select_test;
	import wtprs_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASES       = 8;
	localparam int PHASE_BEATS  = 100;
	localparam int IDLE_PERCENT = 18;
	localparam int DRAIN_CYCLES = LOG_FRAC_BITS + 12;

	typedef struct packed {
		logic [RNG_W-1:0]    upper;
		logic [RNG_W-1:0]    lower;
		logic [FACTOR_W-1:0] factor;
	} range_sel_t;

	typedef struct {
		bit          is_cfg;
		reg_idx_t    idx;
		logic [31:0] value;
		bit          typed;
		range_sel_t  want;
	} plan_row_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid;
	logic                in_ready;
	logic signed [FREQ_W-1:0] frequency;
	logic                out_valid;
	logic                out_ready;
	logic [RNG_W-1:0]    upper_range_index;
	logic [RNG_W-1:0]    lower_range_index;
	logic [FACTOR_W-1:0] interp_factor;

	// Shadow copies of the band select registers.
	logic signed [LOWEST_W-1:0] cfg_lowest;
	logic [RNG_W-1:0]           cfg_ranges;
	logic [BANDS_W-1:0]         cfg_bands;

	range_sel_t  pending_ranges[$];
	range_sel_t  arrived_want;
	plan_row_t   stim_plan[$];
	int          mismatch_count;
	int          cycle_count;
	bit          steady_stretch;

	wavetable_pitch_range_select dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.frequency(frequency),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.upper_range_index(upper_range_index),
		.lower_range_index(lower_range_index),
		.interp_factor(interp_factor)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("== FAIL ==");
		$finish;
	end

	// Log2 by leading-one search and mantissa squaring, then scale, clamp and split.
	function automatic range_sel_t predict_ranges(input logic [FREQ_W-1:0] freq);
		longint     one;
		longint     lowest;
		longint     lg;
		longint     pitch;
		longint     top;
		longint     frac_bits;
		longint     fraction;
		logic [32:0] mag;
		logic [63:0] mant;
		logic [63:0] sq;
		int         msb;
		int         last;
		int         upper;
		range_sel_t res;
		one    = longint'(1) << LOG_FRAC_BITS;
		lowest = longint'(cfg_lowest);
		mag    = freq[FREQ_W-1] ? (33'h1_0000_0000 - {1'b0, freq}) : {1'b0, freq};
		if (mag == 0) begin
			lg = lowest - one;
		end else begin
			msb = 0;
			for (int i = 0; i < 32; i++)
				if (mag[i])
					msb = i;
			mant      = {31'd0, mag} << (31 - msb);
			frac_bits = 0;
			for (int i = 0; i < LOG_FRAC_BITS; i++) begin
				sq = mant * mant;
				if (sq[63]) begin
					frac_bits = frac_bits * 2 + 1;
					mant      = sq >> 32;
				end else begin
					frac_bits = frac_bits * 2;
					mant      = sq >> 31;
				end
			end
			lg = longint'(msb - FREQ_FRAC_BITS) * one + frac_bits;
		end
		pitch = one + longint'(cfg_bands) * (lg - lowest);
		last  = (cfg_ranges == 0) ? 0 : int'(cfg_ranges) - 1;
		top   = longint'(last) * one;
		if (pitch < 0)
			pitch = 0;
		if (pitch > top)
			pitch = top;
		upper    = int'(pitch >>> LOG_FRAC_BITS);
		fraction = pitch & (one - 1);
		if (LOG_FRAC_BITS >= 16)
			fraction = fraction >> (LOG_FRAC_BITS - 16);
		else
			fraction = fraction << (16 - LOG_FRAC_BITS);
		res.upper  = upper[RNG_W-1:0];
		res.lower  = (upper < last) ? RNG_W'(upper + 1) : upper[RNG_W-1:0];
		res.factor = fraction[FACTOR_W-1:0];
		return res;
	endfunction

	function automatic logic [FREQ_W-1:0] random_frequency();
		int unsigned b;
		logic [31:0] mag;
		case ($urandom_range(9))
			0: return '0;
			1: begin
				case ($urandom_range(3))
					0: return 32'h8000_0000;
					1: return 32'h7FFF_FFFF;
					2: return 32'h0000_0001;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			2, 3: return $urandom;
			default: begin
				b   = $urandom_range(30);
				mag = (32'd1 << b) | ($urandom & ((32'd1 << b) - 32'd1));
				return $urandom_range(1) ? -mag : mag;
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// Called at a falling edge with the bus idle; returns at a falling edge with the bus idle again.
	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_LOWEST: cfg_lowest = data[LOWEST_W-1:0];
			REG_RANGES: cfg_ranges = data[RNG_W-1:0];
			REG_BANDS:  cfg_bands  = data[BANDS_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_ranges.size() != 0)
			@(negedge clk);
	endtask

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_freq(input logic [FREQ_W-1:0] value, input bit typed,
			input range_sel_t want);
		while (!steady_stretch && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		frequency <= value;
		do @(posedge clk); while (!in_ready);
		pending_ranges.push_back(typed ? want : predict_ranges(value));
		@(negedge clk);
	endtask

	function automatic void plan_freq(input logic [31:0] value);
		plan_row_t row;
		row = '{1'b0, REG_LOWEST, value, 1'b0, '0};
		stim_plan.push_back(row);
	endfunction

	function automatic void plan_known(input logic [31:0] value, input int upper,
			input int lower, input int factor);
		plan_row_t row;
		row = '{1'b0, REG_LOWEST, value, 1'b1,
			'{upper[RNG_W-1:0], lower[RNG_W-1:0], factor[FACTOR_W-1:0]}};
		stim_plan.push_back(row);
	endfunction

	function automatic void plan_cfg(input reg_idx_t idx, input logic [31:0] value);
		plan_row_t row;
		row = '{1'b1, idx, value, 1'b0, '0};
		stim_plan.push_back(row);
	endfunction

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= steady_stretch || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_ranges.size() == 0) begin
				report_mismatch("result beat with nothing pending", upper_range_index, 0);
			end else begin
				arrived_want = pending_ranges.pop_front();
				if (upper_range_index !== arrived_want.upper)
					report_mismatch("upper_range_index", upper_range_index, arrived_want.upper);
				if (lower_range_index !== arrived_want.lower)
					report_mismatch("lower_range_index", lower_range_index, arrived_want.lower);
				if (interp_factor !== arrived_want.factor)
					report_mismatch("interp_factor", interp_factor, arrived_want.factor);
			end
		end
	end

	initial begin
		logic [31:0] garbage;
		mismatch_count = 0;
		steady_stretch = 1'b0;
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		in_valid       = 1'b0;
		frequency      = '0;
		cfg_lowest     = LOWEST_RST;
		cfg_ranges     = RANGES_RST;
		cfg_bands      = BANDS_RST;

		// Directed table. Typed results are the clamped corners; the rest go to the predictor.
		plan_known(32'h0000_0000, 0, 1, 0);
		plan_known(32'h0000_0001, 0, 1, 0);
		plan_known(32'hFFFF_FFFF, 0, 1, 0);
		plan_known(32'h7FFF_FFFF, 35, 35, 0);
		plan_known(32'h8000_0000, 35, 35, 0);
		plan_known(32'h0000_0100, 0, 1, 0);
		plan_freq(32'd112640);
		plan_freq(-32'sd112640);
		plan_freq(32'd2758);
		plan_freq(32'd256000);
		// With no tables configured, everything lands on index zero.
		plan_cfg(REG_RANGES, 32'd0);
		plan_known(32'd112640, 0, 0, 0);
		plan_known(32'h0000_0000, 0, 0, 0);
		plan_cfg(REG_RANGES, 32'd63);
		plan_cfg(REG_BANDS, 32'd15);
		plan_known(32'h8000_0000, 62, 62, 0);
		plan_freq(32'd256000);
		// Zero bands per octave pins the pitch range at one.
		plan_cfg(REG_BANDS, 32'd0);
		plan_known(32'd12345, 1, 2, 0);
		plan_known(32'h0000_0000, 1, 2, 0);
		plan_cfg(REG_BANDS, 32'd12);
		plan_cfg(REG_LOWEST, 32'h0080_0000);
		plan_known(32'h0000_0001, 62, 62, 0);
		plan_cfg(REG_LOWEST, 32'h007F_FFFF);
		plan_known(32'h7FFF_FFFF, 0, 1, 0);
		plan_known(32'h0000_0000, 0, 1, 0);
		plan_cfg(REG_RANGES, 32'd1);
		plan_known(32'h7FFF_FFFF, 0, 0, 0);
		plan_cfg(REG_LOWEST, 32'(LOWEST_RST));
		plan_cfg(REG_RANGES, 32'(RANGES_RST));
		plan_cfg(REG_BANDS, 32'(BANDS_RST));

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (stim_plan[i]) begin
			if (stim_plan[i].is_cfg) begin
				wait_drained();
				write_reg(stim_plan[i].idx, stim_plan[i].value);
			end else begin
				send_freq(stim_plan[i].value, stim_plan[i].typed, stim_plan[i].want);
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase != 0) begin
				wait_drained();
				// Upper bits beyond each register's width carry noise.
				garbage = $urandom;
				if ($urandom_range(3) == 0)
					write_reg(REG_LOWEST, garbage);
				else
					write_reg(REG_LOWEST, {garbage[31:24],
						24'($urandom_range(31 * 65536) - 8 * 65536)});
				garbage = $urandom;
				case ($urandom_range(7))
					0: write_reg(REG_RANGES, {garbage[31:6], 6'd0});
					1: write_reg(REG_RANGES, {garbage[31:6], 6'd1});
					2: write_reg(REG_RANGES, {garbage[31:6], 6'd63});
					default: write_reg(REG_RANGES,
						{garbage[31:6], 6'($urandom_range(63, 2))});
				endcase
				garbage = $urandom;
				write_reg(REG_BANDS, {garbage[31:4], 4'($urandom_range(15))});
			end
			steady_stretch = (phase == 3);
			for (int n = 0; n < PHASE_BEATS; n++)
				send_freq(random_frequency(), 1'b0, '0);
		end
		steady_stretch = 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/wtprs_pkg.sv
rtl/wtprs_log2.sv
rtl/wavetable_pitch_range_select.sv
rtl/wtprs_checker.sv
bench/wavetable_pitch_range_select_test.sv
